>>> hdl/quaternion_to_yaw_assert.svh
// Assertion macros for the quaternion-to-yaw pipeline.
// Included by the top level; no other dependencies.
`ifndef QUATERNION_TO_YAW_ASSERT_SVH
`define QUATERNION_TO_YAW_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset
`define Q2Y_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, checked outside reset
`define Q2Y_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define Q2Y_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define Q2Y_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/q2y_pkg.sv
// Shared types and constants for the quaternion-to-yaw pipeline.
// No dependencies.
package q2y_pkg;

    // Number of CORDIC iterations, one register stage each (8 to 32)
    localparam int CordicStages = 16;
    localparam int NumStages    = (CordicStages > 32) ? 32 : CordicStages;

    localparam int QuatW  = 16;
    localparam int ProdW  = 32;
    localparam int NumW   = 34;
    localparam int DenW   = 33;
    localparam int PreSh  = 24;
    localparam int XyW    = 60;
    localparam int AccW   = 32;
    localparam int ShiftW = 5;
    localparam int YawW   = 16;

    // Binary angle of pi in the accumulator
    localparam logic [AccW-1:0] AccPi = 32'h8000_0000;

    // atan(2^-i) scaled so that 2^31 is pi, rounded to nearest
    localparam logic [AccW-1:0] AtanTable [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Word carried between CORDIC stages
    typedef struct packed {
        logic signed [XyW-1:0] x;
        logic signed [XyW-1:0] y;
        logic [AccW-1:0]       acc;
        logic                  special;  // numerator and denominator both zero
        logic                  zero;     // all four components zero
    } t_cordic;

endpackage

>>> hdl/q2y_in_if.sv
// Input channel carrying one quaternion word.
// No dependencies.
interface q2y_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

>>> hdl/q2y_out_if.sv
// Output channel carrying one yaw word.
// No dependencies.
interface q2y_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] yaw_angle;
    logic               zero_quat;

    modport source (output valid, output yaw_angle, output zero_quat, input ready);
    modport sink   (input valid, input yaw_angle, input zero_quat, output ready);
endinterface

>>> hdl/q2y_front.sv
// Front end: products, numerator/denominator sums and CORDIC pre-rotation.
// Three register stages; depends on q2y_pkg.
module q2y_front
    import q2y_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [QuatW-1:0] i_w,
    input  logic signed [QuatW-1:0] i_x,
    input  logic signed [QuatW-1:0] i_y,
    input  logic signed [QuatW-1:0] i_z,
    output logic                    o_valid,
    output t_cordic                 o_data
);

    logic signed [ProdW-1:0] r_wz, r_xy, r_ww, r_xx, r_yy, r_zz;
    logic                    r_zero1, r_zero2;
    logic signed [NumW-1:0]  r_num;
    logic signed [DenW-1:0]  r_den;
    logic signed [NumW-1:0]  n_num;
    logic signed [DenW-1:0]  n_den;
    logic signed [XyW-1:0]   n_x0, n_y0;
    t_cordic                 n_data, r_data;
    logic [2:0]              r_vld;

    // Advance valid bits with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // Stage 1: six products and the all-zero flag
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wz    <= ProdW'(i_w) * ProdW'(i_z);
            r_xy    <= ProdW'(i_x) * ProdW'(i_y);
            r_ww    <= ProdW'(i_w) * ProdW'(i_w);
            r_xx    <= ProdW'(i_x) * ProdW'(i_x);
            r_yy    <= ProdW'(i_y) * ProdW'(i_y);
            r_zz    <= ProdW'(i_z) * ProdW'(i_z);
            r_zero1 <= (i_w == '0) && (i_x == '0) && (i_y == '0) && (i_z == '0);
        end
    end

    // Stage 2: num = 2(wz+xy), den = w^2+x^2-y^2-z^2
    always_comb begin
        n_num = (NumW'(r_wz) + NumW'(r_xy)) <<< 1;
        n_den = DenW'(r_ww) + DenW'(r_xx) - DenW'(r_yy) - DenW'(r_zz);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num   <= n_num;
            r_den   <= n_den;
            r_zero2 <= r_zero1;
        end
    end

    // Stage 3: scale up and rotate into the right half plane
    always_comb begin
        n_x0 = XyW'(r_den) <<< PreSh;
        n_y0 = XyW'(r_num) <<< PreSh;
        n_data.special = (r_num == '0) && (r_den == '0);
        n_data.zero    = r_zero2;
        if (r_den[DenW-1]) begin
            n_data.x   = -n_x0;
            n_data.y   = -n_y0;
            n_data.acc = AccPi;
        end else begin
            n_data.x   = n_x0;
            n_data.y   = n_y0;
            n_data.acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld[2];
    assign o_data  = r_data;

endmodule

>>> hdl/q2y_cordic_stage.sv
// One vectoring CORDIC iteration with its output register.
// Depends on q2y_pkg.
module q2y_cordic_stage
    import q2y_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [ShiftW-1:0] i_shift,
    input  logic [AccW-1:0]   i_atan,
    input  logic              i_valid,
    input  t_cordic           i_data,
    output logic              o_valid,
    output t_cordic           o_data
);

    logic signed [XyW-1:0] xs, ys;
    t_cordic               n_data, r_data;
    logic                  r_valid;

    // Rotate toward the x axis by atan(2^-i)
    always_comb begin
        xs     = i_data.x >>> i_shift;
        ys     = i_data.y >>> i_shift;
        n_data = i_data;
        if (!i_data.y[XyW-1]) begin
            n_data.x   = i_data.x + ys;
            n_data.y   = i_data.y - xs;
            n_data.acc = i_data.acc + i_atan;
        end else begin
            n_data.x   = i_data.x - ys;
            n_data.y   = i_data.y + xs;
            n_data.acc = i_data.acc - i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/quaternion_to_yaw.sv
// Quaternion to yaw angle: atan2(2(wz+xy), w^2+x^2-y^2-z^2) by pipelined CORDIC.
// Stages: 3 front stages + one stage per CORDIC iteration + 1 output register.
// Throughput: one word per cycle when the pipeline is not held.
// The whole pipeline holds while the output register is full and not taken.
// Synchronous active-low reset empties the pipeline; no word is taken in reset.
// Depends on q2y_pkg, q2y_in_if, q2y_out_if, q2y_front, q2y_cordic_stage.
`include "quaternion_to_yaw_assert.svh"
module quaternion_to_yaw
    import q2y_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    q2y_in_if.sink    i_quat,
    q2y_out_if.source o_yaw
);

    logic                   w_en;
    logic                   w_vld [NumStages+1];
    t_cordic                w_chain [NumStages+1];
    t_cordic                w_last;
    logic                   r_out_valid;
    logic signed [YawW-1:0] r_yaw;
    logic                   r_zero;
    logic [YawW-1:0]        n_yaw;

    // Advance everything unless a finished word waits
    assign w_en         = !r_out_valid || o_yaw.ready;
    assign i_quat.ready = w_en && i_rst_n;

    q2y_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_quat.valid && i_quat.ready),
        .i_w     (i_quat.quat_w),
        .i_x     (i_quat.quat_x),
        .i_y     (i_quat.quat_y),
        .i_z     (i_quat.quat_z),
        .o_valid (w_vld[0]),
        .o_data  (w_chain[0])
    );

    // One register stage per CORDIC iteration
    for (genvar k = 0; k < NumStages; k++) begin : g_stage
        q2y_cordic_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_shift (ShiftW'(k)),
            .i_atan  (AtanTable[k]),
            .i_valid (w_vld[k]),
            .i_data  (w_chain[k]),
            .o_valid (w_vld[k+1]),
            .o_data  (w_chain[k+1])
        );
    end

    assign w_last = w_chain[NumStages];

    // Round to 16 bits; force zero for a degenerate vector
    always_comb begin
        n_yaw = w_last.acc[AccW-1 -: YawW] + YawW'(w_last.acc[AccW-YawW-1]);
        if (w_last.special) begin
            n_yaw = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_vld[NumStages];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_yaw  <= $signed(n_yaw);
            r_zero <= w_last.zero;
        end
    end

    assign o_yaw.valid     = r_out_valid;
    assign o_yaw.yaw_angle = r_yaw;
    assign o_yaw.zero_quat = r_zero;

    // An all-zero quaternion always reports yaw zero
    `Q2Y_ASSERT_NOW(a_zero_yaw, i_clk, i_rst_n, o_yaw.valid && o_yaw.zero_quat, o_yaw.yaw_angle == '0)
    // Input is refused only while a finished word is stalled
    `Q2Y_ASSERT_NOW(a_stall_only, i_clk, i_rst_n, !i_quat.ready, r_out_valid && !o_yaw.ready)
    // A word leaving the last stage on an advance lands in the output register
    `Q2Y_ASSERT_NEXT(a_land, i_clk, i_rst_n, w_en && w_vld[NumStages], o_yaw.valid)

endmodule

>>> dv/tb_quaternion_to_yaw.sv
// Testbench for quaternion_to_yaw: drives quaternion words with bursty traffic and
// checks each yaw word against a bit-exact CORDIC predictor kept here.
// Depends on q2y_pkg, q2y_in_if, q2y_out_if and the quaternion_to_yaw RTL.
module tb_quaternion_to_yaw
    import q2y_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Iters       = (CordicStages > 32) ? 32 : CordicStages;
    localparam int RandWords   = 1000;
    localparam int HoldCycles  = 80;
    localparam int DrainCycles = 40;
    localparam int IdleLimit   = 2000;
    localparam int MaxReports  = 10;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic               zero;
    } t_yaw_word;

    typedef struct {
        int w;
        int x;
        int y;
        int z;
        bit typed;
        int yaw;
        bit zero;
    } t_dir_row;

    // atan(2^-i) with 2^31 meaning pi, rounded to nearest
    localparam logic [31:0] ArcTan [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Directed words; typed rows carry the yaw word that is known up front
    t_dir_row dir_rows [24] = '{
        '{0, 0, 0, 0, 1'b1, 0, 1'b1},                       // all-zero quaternion
        '{1, 0, 1, 0, 1'b1, 0, 1'b0},                       // gimbal lock
        '{100, 200, 100, -200, 1'b1, 0, 1'b0},              // gimbal lock
        '{-32768, 0, -32768, 0, 1'b1, 0, 1'b0},             // gimbal lock at extreme
        '{32767, 0, 0, 0, 1'b0, 0, 1'b0},
        '{0, 0, 0, 32767, 1'b0, 0, 1'b0},                   // negative den, near pi
        '{-32768, -32768, -32768, -32768, 1'b0, 0, 1'b0},
        '{32767, 32767, 32767, 32767, 1'b0, 0, 1'b0},
        '{-32768, 32767, -32768, 32767, 1'b0, 0, 1'b0},
        '{32767, -32768, 32767, -32768, 1'b0, 0, 1'b0},
        '{1, 0, 0, 0, 1'b0, 0, 1'b0},
        '{0, 1, 0, 0, 1'b0, 0, 1'b0},
        '{0, 0, 1, 0, 1'b0, 0, 1'b0},
        '{0, 0, 0, 1, 1'b0, 0, 1'b0},
        '{-1, -1, -1, -1, 1'b0, 0, 1'b0},
        '{23170, 0, 0, 23170, 1'b0, 0, 1'b0},
        '{23170, 0, 0, -23170, 1'b0, 0, 1'b0},
        '{0, -32768, 0, 0, 1'b0, 0, 1'b0},
        '{0, 0, -32768, 0, 1'b0, 0, 1'b0},
        '{-32768, 0, 0, 0, 1'b0, 0, 1'b0},
        '{0, 0, 0, -32768, 1'b0, 0, 1'b0},
        '{1, 0, 0, -1, 1'b0, 0, 1'b0},
        '{1, 2, 3, -4, 1'b0, 0, 1'b0},
        '{-32768, 32767, 0, 1, 1'b0, 0, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    q2y_in_if  quat_ch ();
    q2y_out_if yaw_ch ();

    quaternion_to_yaw u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat_ch),
        .o_yaw   (yaw_ch)
    );

    t_yaw_word yaw_expected [$];
    int        fail_count;
    int        idle_cycles;
    bit        yaw_hold_req;

    // Clock: 10 ns period
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Yaw of one quaternion: numerator and denominator of atan2, then vectoring CORDIC
    function automatic t_yaw_word predict_yaw(t_quat q);
        longint      w, x, y, z, num, den, vx, vy, sx, sy;
        logic [31:0] angle;
        logic [31:0] rounded;
        t_yaw_word   r;
        int          i;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        num = 2 * (w * z + x * y);
        den = w * w + x * x - y * y - z * z;
        r.zero = (w == 0 && x == 0 && y == 0 && z == 0);
        r.yaw  = '0;
        if (!r.zero && !(num == 0 && den == 0)) begin
            vx = den * 64'sd16777216;
            vy = num * 64'sd16777216;
            angle = '0;
            // Fold the left half plane onto the right, starting the angle at pi
            if (vx < 0) begin
                vx = -vx;
                vy = -vy;
                angle = 32'h8000_0000;
            end
            for (i = 0; i < Iters; i++) begin
                sx = vx >>> i;
                sy = vy >>> i;
                if (vy >= 0) begin
                    vx = vx + sy;
                    vy = vy - sx;
                    angle = angle + ArcTan[i];
                end else begin
                    vx = vx - sy;
                    vy = vy + sx;
                    angle = angle - ArcTan[i];
                end
            end
            rounded = angle + 32'h0000_8000;
            r.yaw   = rounded[31:16];
        end
        return r;
    endfunction

    function automatic void note_mismatch(string what);
        fail_count++;
        if (fail_count <= MaxReports) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Offer one word at the current falling edge, hold until taken, queue its yaw
    task automatic send_quat(input t_quat q, input bit typed, input t_yaw_word typed_res);
        t_yaw_word exp_word;
        quat_ch.quat_w = q.w;
        quat_ch.quat_x = q.x;
        quat_ch.quat_y = q.y;
        quat_ch.quat_z = q.z;
        quat_ch.valid  = 1'b1;
        do @(posedge i_clk); while (!quat_ch.ready);
        exp_word     = typed ? typed_res : predict_yaw(q);
        yaw_expected = {yaw_expected, exp_word};
        @(negedge i_clk);
    endtask

    // Stimulus: reset, directed table, then bursty random words
    initial begin : quat_source
        t_quat       q;
        t_yaw_word   typed_res;
        int          burst_left;
        int          gap;
        int          pick;
        int          mag;
        int          n;
        logic [15:0] corner [7];
        corner = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF};
        i_rst_n        = 1'b0;
        yaw_hold_req   = 1'b0;
        quat_ch.valid  = 1'b0;
        quat_ch.quat_w = '0;
        quat_ch.quat_x = '0;
        quat_ch.quat_y = '0;
        quat_ch.quat_z = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            q.w = 16'(dir_rows[r].w);
            q.x = 16'(dir_rows[r].x);
            q.y = 16'(dir_rows[r].y);
            q.z = 16'(dir_rows[r].z);
            typed_res.yaw  = 16'(dir_rows[r].yaw);
            typed_res.zero = dir_rows[r].zero;
            send_quat(q, dir_rows[r].typed, typed_res);
        end

        // Pause until the directed words have all come back
        quat_ch.valid = 1'b0;
        while (yaw_expected.size() != 0) @(negedge i_clk);

        burst_left = 0;
        typed_res  = '0;
        for (n = 0; n < RandWords; n++) begin
            if (n == RandWords / 3) yaw_hold_req = 1'b1;
            // Pause again until the pipeline has drained
            if (n == (2 * RandWords) / 3) begin
                quat_ch.valid = 1'b0;
                while (yaw_expected.size() != 0) @(negedge i_clk);
            end
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    quat_ch.valid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst_left = $urandom_range(1, 60);
            end
            burst_left--;

            pick = $urandom_range(0, 99);
            q.w = 16'($urandom);
            q.x = 16'($urandom);
            q.y = 16'($urandom);
            q.z = 16'($urandom);
            if (pick < 45) begin
                // full-range components, kept as drawn
            end else if (pick < 65) begin
                // small magnitudes exercise precision of the pre-shift
                mag = 1 << $urandom_range(0, 10);
                q.w = 16'(int'($urandom_range(0, 2 * mag)) - mag);
                q.x = 16'(int'($urandom_range(0, 2 * mag)) - mag);
                q.y = 16'(int'($urandom_range(0, 2 * mag)) - mag);
                q.z = 16'(int'($urandom_range(0, 2 * mag)) - mag);
            end else if (pick < 75) begin
                q.w = corner[$urandom_range(0, 6)];
                q.x = corner[$urandom_range(0, 6)];
                q.y = corner[$urandom_range(0, 6)];
                q.z = corner[$urandom_range(0, 6)];
            end else if (pick < 85) begin
                // gimbal lock: numerator and denominator cancel
                if ($urandom_range(0, 1) == 1) begin
                    q.y = q.w;
                    q.z = -q.x;
                end else begin
                    q.y = -q.w;
                    q.z = q.x;
                end
            end else if (pick < 90) begin
                // zero quaternion, or a single nonzero component
                q = '0;
                case ($urandom_range(0, 4))
                    0: q.w = 16'($urandom);
                    1: q.x = 16'($urandom);
                    2: q.y = 16'($urandom);
                    3: q.z = 16'($urandom);
                    default: ;
                endcase
            end else begin
                // angle close to +-pi, where rounding may wrap
                q.w = 16'(int'($urandom_range(0, 6)) - 3);
                q.x = 16'(int'($urandom_range(0, 6)) - 3);
            end
            send_quat(q, 1'b0, typed_res);
        end
        quat_ch.valid = 1'b0;

        while (yaw_expected.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && yaw_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Receiver: ready on a pattern of its own, plus one long hold-off on request
    initial begin : yaw_sink
        int mode;
        int seg_left;
        int hold_cnt;
        yaw_ch.ready = 1'b0;
        mode     = 0;
        seg_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (yaw_hold_req) begin
                yaw_ch.ready = 1'b0;
                for (hold_cnt = 0; hold_cnt < HoldCycles; hold_cnt++) @(negedge i_clk);
                yaw_hold_req = 1'b0;
            end
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(10, 150);
            end
            seg_left--;
            case (mode)
                0: yaw_ch.ready = 1'b1;
                1: yaw_ch.ready = 1'($urandom_range(0, 1));
                2: yaw_ch.ready = (seg_left % 4 == 0);
                default: yaw_ch.ready = ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Compare each taken yaw word with the oldest expectation
    always @(posedge i_clk) begin : yaw_check
        t_yaw_word want;
        if (i_rst_n && yaw_ch.valid && yaw_ch.ready) begin
            if (yaw_expected.size() == 0) begin
                note_mismatch($sformatf("unexpected word yaw=%0d zero=%0b",
                                        yaw_ch.yaw_angle, yaw_ch.zero_quat));
            end else begin
                want = yaw_expected.pop_front();
                if (yaw_ch.yaw_angle !== want.yaw || yaw_ch.zero_quat !== want.zero) begin
                    note_mismatch($sformatf("yaw exp=%0d got=%0d, zero exp=%0b got=%0b",
                                            want.yaw, yaw_ch.yaw_angle,
                                            want.zero, yaw_ch.zero_quat));
                end
            end
        end
    end

    // Watchdog: end the run when no word moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (quat_ch.valid && quat_ch.ready) || (yaw_ch.valid && yaw_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule

>>> files.f
+incdir+hdl
hdl/q2y_pkg.sv
hdl/q2y_in_if.sv
hdl/q2y_out_if.sv
hdl/q2y_front.sv
hdl/q2y_cordic_stage.sv
hdl/quaternion_to_yaw.sv
dv/tb_quaternion_to_yaw.sv
